// ===== rtl/orl_pkg.sv =====
// Shared definitions for the ordered record list: command and status codes,
// cell operation codes and the structs passed between top level and cells.
// No dependencies.
`default_nettype none

package orl_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int KEY_W          = 64;
    localparam int POS_W          = 7;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_NAME  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND_PHONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_NAME = 3'd4;

    // operation broadcast to every cell
    localparam logic [2:0] CELL_HOLD       = 3'd0;
    localparam logic [2:0] CELL_INSERT     = 3'd1;
    localparam logic [2:0] CELL_REMOVE     = 3'd2;
    localparam logic [2:0] CELL_FIND_NAME  = 3'd3;
    localparam logic [2:0] CELL_FIND_PHONE = 3'd4;
    localparam logic [2:0] CELL_FIND_POS   = 3'd5;

    typedef struct packed {
        logic [2:0]       op;
        logic [KEY_W-1:0] name_key;
        logic [KEY_W-1:0] phone_key;
    } t_bcast;

    // record travelling down the lookup chain towards cell 0
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] name;
        logic [KEY_W-1:0] phone;
    } t_carry;

endpackage

`default_nettype wire

// ===== rtl/ordered_record_list.sv =====
// Top level of the ordered record list: command sequencer, result register
// and the chain of orl_cell record cells. Uses orl_pkg and orl_cell.
//
// One command transaction enters on i_valid/o_ready with cmd, position,
// name_key and phone_key; one result transaction leaves on o_valid/i_ready
// with status, found_position, out_name, out_phone and entry_total.
// Cell k holds list position k+1; insert and delete shift the cells at and
// above the position by one place. Lookups (find, read, and the fetch of
// the record removed by delete) run on a chain of carry registers: each
// cell passes its own record if it matches, else its upper neighbour's
// carry, one cell per cycle towards cell 0.
// Insert, failed checks and unknown commands go from EXEC to RESULT;
// find, read and delete pass through SCAN and FINISH first. One command is
// in progress at a time; o_ready rises together with o_valid, so a new
// command is accepted only after the previous result has left RESULT.
// Synchronous active-low reset empties the list and drops any pending
// result; record contents are not cleared. While the receiver stalls the
// output register holds its result and a following command waits in the
// result stage until the register frees up.
`default_nettype none

module ordered_record_list #(
    parameter int LIST_DEPTH = orl_pkg::LIST_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [orl_pkg::CMD_W-1:0]       i_cmd,
    input  logic [orl_pkg::POS_W-1:0]       i_position,
    input  logic [orl_pkg::KEY_W-1:0]       i_name_key,
    input  logic [orl_pkg::KEY_W-1:0]       i_phone_key,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [orl_pkg::STATUS_W-1:0]    o_status,
    output logic [orl_pkg::POS_W-1:0]       o_found_position,
    output logic [orl_pkg::KEY_W-1:0]       o_out_name,
    output logic [orl_pkg::KEY_W-1:0]       o_out_phone,
    output logic [orl_pkg::POS_W-1:0]       o_entry_total
);
    import orl_pkg::*;

    localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(LIST_DEPTH);
    localparam logic [IW-1:0]   SCAN_LAST = IW'(LIST_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [POS_W-1:0]    r_pos;
    logic [KEY_W-1:0]    r_name_key, r_phone_key;
    logic [CW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_scan, n_scan;

    // result stage
    logic [STATUS_W-1:0] r_p_status, n_p_status;
    logic [POS_W-1:0]    r_p_fpos, n_p_fpos;
    logic [KEY_W-1:0]    r_p_name, n_p_name;
    logic [KEY_W-1:0]    r_p_phone, n_p_phone;
    logic [POS_W-1:0]    r_p_total, n_p_total;

    // output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [POS_W-1:0]    r_o_fpos;
    logic [KEY_W-1:0]    r_o_name, r_o_phone;
    logic [POS_W-1:0]    r_o_total;

    t_bcast              w_bc;
    logic [IW-1:0]       w_sel;
    logic [CMPW-1:0]     pos_ext, cnt_ext, pos_m1;
    logic                pos_zero;
    logic                ins_ok;
    logic                out_free;
    logic                load_out;

    logic [KEY_W-1:0]    w_name  [LIST_DEPTH];
    logic [KEY_W-1:0]    w_phone [LIST_DEPTH];
    t_carry              w_carry [LIST_DEPTH+1];

    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_o_valid || i_ready;
    assign load_out = (r_state == S_RESULT) && out_free;

    assign pos_ext  = CMPW'(r_pos);
    assign cnt_ext  = CMPW'(r_count);
    assign pos_m1   = pos_ext - CMPW'(1);
    assign pos_zero = (r_pos == '0);
    assign w_sel    = IW'(pos_m1);
    assign ins_ok   = (r_name_key != '0) && (cnt_ext < DEPTH_C) && !pos_zero
                      && (pos_ext <= cnt_ext + CMPW'(1));

    // Sequencer: decide checks (and insert) in EXEC, run the lookup chain in SCAN,
    // collect the chain head (and remove the record on delete) in FINISH, hand over in RESULT.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_scan     = r_scan;
        n_p_status = r_p_status;
        n_p_fpos   = r_p_fpos;
        n_p_name   = r_p_name;
        n_p_phone  = r_p_phone;
        n_p_total  = r_p_total;
        w_bc.op        = CELL_HOLD;
        w_bc.name_key  = r_name_key;
        w_bc.phone_key = r_phone_key;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_p_status = ST_OK;
                n_p_fpos   = '0;
                n_p_name   = '0;
                n_p_phone  = '0;
                n_p_total  = POS_W'(r_count);
                n_state    = S_RESULT;
                n_scan     = '0;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        priority if (r_name_key == '0) begin
                            n_p_status = ST_EMPTY_NAME;
                        end else if (cnt_ext >= DEPTH_C) begin
                            n_p_status = ST_FULL;
                        end else if (!ins_ok) begin
                            n_p_status = ST_BAD_POS;
                        end else begin
                            w_bc.op   = CELL_INSERT;
                            n_count   = r_count + CW'(1);
                            n_p_fpos  = r_pos;
                            n_p_total = POS_W'(r_count + CW'(1));
                        end
                    end
                    CMD_DELETE, CMD_READ: begin
                        if (pos_zero || (pos_ext > cnt_ext)) begin
                            n_p_status = ST_BAD_POS;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    CMD_FIND_NAME, CMD_FIND_PHONE: begin
                        n_state = S_SCAN;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                unique case (r_cmd)
                    CMD_FIND_NAME:  w_bc.op = CELL_FIND_NAME;
                    CMD_FIND_PHONE: w_bc.op = CELL_FIND_PHONE;
                    default:        w_bc.op = CELL_FIND_POS;
                endcase
                if (r_scan == SCAN_LAST) begin
                    n_state = S_FINISH;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            S_FINISH: begin
                n_state = S_RESULT;
                if (w_carry[0].found) begin
                    n_p_status = ST_OK;
                    n_p_fpos   = w_carry[0].pos;
                    n_p_name   = w_carry[0].name;
                    n_p_phone  = w_carry[0].phone;
                end else begin
                    n_p_status = ST_NOT_FOUND;
                    n_p_fpos   = '0;
                    n_p_name   = '0;
                    n_p_phone  = '0;
                end
                n_p_total = POS_W'(r_count);
                if (r_cmd == CMD_DELETE) begin
                    // record already captured from the chain: close the gap
                    w_bc.op   = CELL_REMOVE;
                    n_count   = r_count - CW'(1);
                    n_p_total = POS_W'(r_count - CW'(1));
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_scan    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_scan  <= n_scan;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd       <= i_cmd;
            r_pos       <= i_position;
            r_name_key  <= i_name_key;
            r_phone_key <= i_phone_key;
        end
        r_p_status <= n_p_status;
        r_p_fpos   <= n_p_fpos;
        r_p_name   <= n_p_name;
        r_p_phone  <= n_p_phone;
        r_p_total  <= n_p_total;
        if (load_out) begin
            r_o_status <= r_p_status;
            r_o_fpos   <= r_p_fpos;
            r_o_name   <= r_p_name;
            r_o_phone  <= r_p_phone;
            r_o_total  <= r_p_total;
        end
    end

    // Row of record cells; the carry chain ends above the top cell empty.
    assign w_carry[LIST_DEPTH] = '0;

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] lower_name, lower_phone;
        logic [KEY_W-1:0] upper_name, upper_phone;

        if (g == 0) begin : g_bottom
            assign lower_name  = '0;
            assign lower_phone = '0;
        end else begin : g_lower
            assign lower_name  = w_name[g-1];
            assign lower_phone = w_phone[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_top
            assign upper_name  = '0;
            assign upper_phone = '0;
        end else begin : g_upper
            assign upper_name  = w_name[g+1];
            assign upper_phone = w_phone[g+1];
        end

        orl_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_bc          (w_bc),
            .i_sel         (w_sel),
            .i_count       (r_count),
            .i_lower_name  (lower_name),
            .i_lower_phone (lower_phone),
            .i_upper_name  (upper_name),
            .i_upper_phone (upper_phone),
            .i_carry       (w_carry[g+1]),
            .o_name        (w_name[g]),
            .o_phone       (w_phone[g]),
            .o_carry       (w_carry[g])
        );
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_fpos;
    assign o_out_name       = r_o_name;
    assign o_out_phone      = r_o_phone;
    assign o_entry_total    = r_o_total;

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted command did not enter EXEC");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_count) <= DEPTH_C))
        else $error("entry count beyond list depth");

    a_scan_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)))
        else $error("entry count changed during lookup");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd == CMD_INSERT && ins_ok)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("successful insert did not grow the list");
`endif

endmodule

`default_nettype wire

// ===== rtl/orl_cell.sv =====
// One record cell of the ordered record list: holds a name and a phone key,
// shifts with its neighbours and forwards the lookup chain. Uses orl_pkg.
`default_nettype none

module orl_cell #(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
) (
    input  logic                            i_clk,
    input  orl_pkg::t_bcast                 i_bc,
    input  logic [IW-1:0]                   i_sel,
    input  logic [CW-1:0]                   i_count,
    input  logic [orl_pkg::KEY_W-1:0]       i_lower_name,
    input  logic [orl_pkg::KEY_W-1:0]       i_lower_phone,
    input  logic [orl_pkg::KEY_W-1:0]       i_upper_name,
    input  logic [orl_pkg::KEY_W-1:0]       i_upper_phone,
    input  orl_pkg::t_carry                 i_carry,
    output logic [orl_pkg::KEY_W-1:0]       o_name,
    output logic [orl_pkg::KEY_W-1:0]       o_phone,
    output orl_pkg::t_carry                 o_carry
);
    import orl_pkg::*;

    localparam logic [IW-1:0] IDX_V = IW'(IDX);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [KEY_W-1:0] r_name, n_name;
    logic [KEY_W-1:0] r_phone, n_phone;
    t_carry           r_carry, n_carry;
    logic             hit;
    logic             live;

    always_comb begin
        n_name  = r_name;
        n_phone = r_phone;
        hit     = 1'b0;
        live    = (IDX_C < i_count);
        unique case (i_bc.op)
            CELL_INSERT: begin
                if (IDX_V == i_sel) begin
                    n_name  = i_bc.name_key;
                    n_phone = i_bc.phone_key;
                end else if (IDX_V > i_sel) begin
                    n_name  = i_lower_name;
                    n_phone = i_lower_phone;
                end
            end
            CELL_REMOVE: begin
                if (IDX_V >= i_sel) begin
                    n_name  = i_upper_name;
                    n_phone = i_upper_phone;
                end
            end
            CELL_FIND_NAME:  hit = live && (r_name == i_bc.name_key);
            CELL_FIND_PHONE: hit = live && (r_phone == i_bc.phone_key);
            CELL_FIND_POS:   hit = (IDX_V == i_sel);
            default: ;
        endcase

        // take own record on a hit, otherwise pass the upper neighbour's on
        if (hit) begin
            n_carry.found = 1'b1;
            n_carry.pos   = POS_W'(IDX + 1);
            n_carry.name  = r_name;
            n_carry.phone = r_phone;
        end else begin
            n_carry = i_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_name  <= n_name;
        r_phone <= n_phone;
        r_carry <= n_carry;
    end

    assign o_name  = r_name;
    assign o_phone = r_phone;
    assign o_carry = r_carry;

endmodule

`default_nettype wire

// ===== verif/orl_checker.sv =====
// Result checker for the ordered record list: watches both channels, keeps a
// shadow copy of the list and compares every result with its prediction.
// Depends on orl_pkg.
`default_nettype none

module orl_checker #(
    parameter int LIST_DEPTH = orl_pkg::LIST_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic [orl_pkg::CMD_W-1:0]       i_cmd,
    input  logic [orl_pkg::POS_W-1:0]       i_position,
    input  logic [orl_pkg::KEY_W-1:0]       i_name_key,
    input  logic [orl_pkg::KEY_W-1:0]       i_phone_key,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [orl_pkg::STATUS_W-1:0]    i_status,
    input  logic [orl_pkg::POS_W-1:0]       i_found_position,
    input  logic [orl_pkg::KEY_W-1:0]       i_out_name,
    input  logic [orl_pkg::KEY_W-1:0]       i_out_phone,
    input  logic [orl_pkg::POS_W-1:0]       i_entry_total,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    import orl_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    found_position;
        logic [KEY_W-1:0]    out_name;
        logic [KEY_W-1:0]    out_phone;
        logic [POS_W-1:0]    entry_total;
    } t_result;

    logic [KEY_W-1:0] name_cells  [LIST_DEPTH];
    logic [KEY_W-1:0] phone_cells [LIST_DEPTH];
    int               rec_count;
    t_result          answer_q [$];
    int               accepted   = 0;
    int               delivered  = 0;
    int               mismatches = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = accepted - delivered;

    // Apply one command to the shadow list and work out its answer.
    task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic [KEY_W-1:0] nkey, input logic [KEY_W-1:0] pkey,
                                 output t_result ans);
        int p;
        int hit;
        p   = int'(pos);
        hit = -1;
        ans = '0;
        ans.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (nkey == '0) begin
                    ans.status = ST_EMPTY_NAME;
                end else if (rec_count >= LIST_DEPTH) begin
                    ans.status = ST_FULL;
                end else if (p < 1 || p > rec_count + 1) begin
                    ans.status = ST_BAD_POS;
                end else begin
                    for (int j = rec_count; j > p - 1; j--) begin
                        name_cells[j]  = name_cells[j-1];
                        phone_cells[j] = phone_cells[j-1];
                    end
                    name_cells[p-1]  = nkey;
                    phone_cells[p-1] = pkey;
                    rec_count++;
                    ans.found_position = pos;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > rec_count) begin
                    ans.status = ST_BAD_POS;
                end else begin
                    ans.found_position = pos;
                    ans.out_name       = name_cells[p-1];
                    ans.out_phone      = phone_cells[p-1];
                    for (int j = p - 1; j + 1 < rec_count; j++) begin
                        name_cells[j]  = name_cells[j+1];
                        phone_cells[j] = phone_cells[j+1];
                    end
                    rec_count--;
                end
            end
            CMD_FIND_NAME, CMD_FIND_PHONE: begin
                for (int j = 0; j < rec_count; j++) begin
                    if (hit < 0 && ((cmd == CMD_FIND_NAME) ? name_cells[j] == nkey
                                                           : phone_cells[j] == pkey))
                        hit = j;
                end
                if (hit < 0) begin
                    ans.status = ST_NOT_FOUND;
                end else begin
                    ans.found_position = POS_W'(hit + 1);
                    ans.out_name       = name_cells[hit];
                    ans.out_phone      = phone_cells[hit];
                end
            end
            CMD_READ: begin
                if (p < 1 || p > rec_count) begin
                    ans.status = ST_BAD_POS;
                end else begin
                    ans.found_position = pos;
                    ans.out_name       = name_cells[p-1];
                    ans.out_phone      = phone_cells[p-1];
                end
            end
            default: ;
        endcase
        ans.entry_total = POS_W'(rec_count);
    endtask

    function automatic int field_differs(string label, logic [KEY_W-1:0] want,
                                         logic [KEY_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, label, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        int      bad;
        if (!i_rst_n) begin
            rec_count = 0;
            answer_q.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                apply_command(i_cmd, i_position, i_name_key, i_phone_key, want);
                answer_q.push_back(want);
                accepted <= accepted + 1;
            end
            if (i_res_valid && i_res_ready) begin
                delivered <= delivered + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: expected no result, actual status %0d position %0d",
                             $time, i_status, i_found_position);
                    mismatches <= mismatches + 1;
                end else begin
                    want = answer_q.pop_front();
                    bad  = field_differs("status", want.status, i_status)
                         + field_differs("found_position", want.found_position,
                                         i_found_position)
                         + field_differs("out_name", want.out_name, i_out_name)
                         + field_differs("out_phone", want.out_phone, i_out_phone)
                         + field_differs("entry_total", want.entry_total, i_entry_total);
                    mismatches <= mismatches + bad;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Top of the ordered record list testbench: clock, reset, command and result
// drivers, and the final verdict. Depends on orl_pkg, ordered_record_list and
// orl_checker.
`default_nettype none

module testbench;

    import orl_pkg::*;

    localparam int DEPTH      = LIST_DEPTH_DEF;
    localparam int ITEM_GOAL  = 1550;
    localparam int PHASE_LEN  = 50;
    localparam int HOLD_LEN   = 400;
    localparam int POOL_SIZE  = 16;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [CMD_W-1:0]    i_cmd;
    logic [POS_W-1:0]    i_position;
    logic [KEY_W-1:0]    i_name_key;
    logic [KEY_W-1:0]    i_phone_key;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [POS_W-1:0]    o_found_position;
    logic [KEY_W-1:0]    o_out_name;
    logic [KEY_W-1:0]    o_out_phone;
    logic [POS_W-1:0]    o_entry_total;

    int mismatches;
    int outstanding;

    // Stimulus-side bookkeeping: a count of live records, used only to aim
    // positions at the interesting range, and pools of keys so finds can hit.
    int               list_fill = 0;
    int               issued    = 0;
    logic [KEY_W-1:0] name_pool  [POOL_SIZE];
    logic [KEY_W-1:0] phone_pool [POOL_SIZE];

    // Handshake shaping between the sender and the receiver process.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    bit hold_req = 1'b0;
    bit rx_on    = 1'b1;
    int rx_left  = 0;

    ordered_record_list #(
        .LIST_DEPTH(DEPTH)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_name_key       (i_name_key),
        .i_phone_key      (i_phone_key),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_out_name       (o_out_name),
        .o_out_phone      (o_out_phone),
        .o_entry_total    (o_entry_total)
    );

    orl_checker #(
        .LIST_DEPTH(DEPTH)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_ready      (o_ready),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_name_key       (i_name_key),
        .i_phone_key      (i_phone_key),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_found_position (o_found_position),
        .i_out_name       (o_out_name),
        .i_out_phone      (o_out_phone),
        .i_entry_total    (o_entry_total),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Generous ceiling: several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result side: drop ready in random stretches, mostly short and a few
    // long; hold it low for a long count when asked, so the block backs up.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready  <= 1'b0;
                hold_req  = 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (rx_quiet) begin
                i_ready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_on = ($urandom_range(0, 99) < 60);
                    if (rx_on)
                        rx_left = $urandom_range(1, 12);
                    else if ($urandom_range(0, 19) == 0)
                        rx_left = $urandom_range(20, 60);
                    else
                        rx_left = $urandom_range(1, 3);
                end
                rx_left--;
                i_ready <= rx_on;
            end
        end
    end

    // Offer one command and hold it until the block takes it.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [KEY_W-1:0] nkey, input logic [KEY_W-1:0] pkey);
        int p;
        p = int'(pos);
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_position  <= pos;
        i_name_key  <= nkey;
        i_phone_key <= pkey;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        issued++;
        // Track the fill level only to steer later positions.
        if (cmd == CMD_INSERT && nkey != '0 && list_fill < DEPTH && p >= 1 && p <= list_fill + 1)
            list_fill++;
        else if (cmd == CMD_DELETE && p >= 1 && p <= list_fill)
            list_fill--;
    endtask

    // Drop valid for a random number of cycles, unless the sender is quiet.
    task automatic sender_gap();
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!tx_quiet) begin
            if (r >= 98)
                gap = $urandom_range(20, 50);
            else if (r >= 90)
                gap = $urandom_range(4, 10);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding > 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_name();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return '0;
        if (r == 1)
            return {$urandom, $urandom};
        if (r == 2)
            return '1;
        return name_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] pick_phone();
        int r;
        r = $urandom_range(0, 31);
        if (r == 0)
            return {$urandom, $urandom};
        if (r == 1)
            return (r == 1 && $urandom_range(0, 1)) ? '1 : '0;
        return phone_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        if ($urandom_range(0, 15) == 0)
            return POS_W'($urandom_range(0, 127));
        if (cmd == CMD_INSERT)
            return POS_W'($urandom_range(1, list_fill + 1));
        if (list_fill == 0)
            return POS_W'($urandom_range(0, 3));
        return POS_W'($urandom_range(1, list_fill));
    endfunction

    // One random command; ins_pct and del_pct tilt the list towards growth
    // or shrinkage, the rest is split among lookups and spare codes.
    task automatic random_command(input int ins_pct, input int del_pct);
        int               r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            cmd = CMD_INSERT;
        end else if (r < ins_pct + del_pct) begin
            cmd = CMD_DELETE;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 35)
                cmd = CMD_FIND_NAME;
            else if (r < 70)
                cmd = CMD_FIND_PHONE;
            else if (r < 95)
                cmd = CMD_READ;
            else
                cmd = CMD_READ + CMD_W'($urandom_range(1, 3));
        end
        sender_gap();
        send_cmd(cmd, pick_position(cmd), pick_name(), pick_phone());
    endtask

    // Insert until the list is full, then knock on the full list a while.
    task automatic fill_list();
        while (list_fill < DEPTH)
            random_command(90, 0);
        repeat (12) random_command(90, 0);
    endtask

    initial begin : stimulus
        int phase;
        int mode;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = CMD_INSERT;
        i_position  = '0;
        i_name_key  = '0;
        i_phone_key = '0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            name_pool[k] = {$urandom, $urandom};
            if (name_pool[k] == '0)
                name_pool[k] = 64'h1;
            for (int d = 0; d < 16; d++)
                phone_pool[k][4*d +: 4] = 4'($urandom_range(0, 9));
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty-list errors first.
        send_cmd(CMD_READ, 7'd1, name_pool[0], phone_pool[0]);
        send_cmd(CMD_DELETE, 7'd1, name_pool[0], phone_pool[0]);
        send_cmd(CMD_FIND_NAME, 7'd0, name_pool[0], phone_pool[0]);
        send_cmd(CMD_FIND_PHONE, 7'd0, name_pool[0], phone_pool[0]);
        // Empty name outranks a bad position; then the position checks.
        send_cmd(CMD_INSERT, 7'd0, '0, phone_pool[0]);
        send_cmd(CMD_INSERT, 7'd0, name_pool[0], phone_pool[0]);
        send_cmd(CMD_INSERT, 7'd2, name_pool[0], phone_pool[0]);
        // Build a small list: first, end, front and middle inserts.
        send_cmd(CMD_INSERT, 7'd1, '1, '0);
        send_cmd(CMD_INSERT, 7'd2, name_pool[0], '1);
        send_cmd(CMD_INSERT, 7'd1, name_pool[1], phone_pool[1]);
        send_cmd(CMD_INSERT, 7'd2, name_pool[0], phone_pool[2]);
        // Duplicate name: the first match must win.
        send_cmd(CMD_FIND_NAME, 7'd0, name_pool[0], '0);
        send_cmd(CMD_FIND_PHONE, 7'd0, '0, '1);
        send_cmd(CMD_FIND_NAME, 7'd0, '0, '0);
        send_cmd(CMD_FIND_PHONE, 7'd0, '0, 64'h0123_4567_8901_2345);
        send_cmd(CMD_READ, 7'd0, '0, '0);
        send_cmd(CMD_READ, 7'd4, '0, '0);
        send_cmd(CMD_READ, 7'd5, '0, '0);
        send_cmd(CMD_READ, 7'd127, '1, '1);
        send_cmd(CMD_DELETE, 7'd127, '1, '1);
        for (int c = int'(CMD_READ) + 1; c < 2 ** CMD_W; c++)
            send_cmd(CMD_W'(c), POS_W'($urandom_range(0, 127)), {$urandom, $urandom},
                     {$urandom, $urandom});
        send_cmd(CMD_DELETE, 7'd2, '0, '0);
        send_cmd(CMD_DELETE, 7'd3, '0, '0);
        send_cmd(CMD_DELETE, 7'd1, '0, '0);

        // Pause the sender until the opening has fully drained.
        drain();

        // Back-pressure: the receiver holds off while the sender keeps going.
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        repeat (PHASE_LEN) random_command(30, 15);
        tx_quiet = 1'b0;

        // Random phases, each leaning towards growth, shrinkage or a mix;
        // some run without any idling, some end in a full drain.
        phase = 0;
        while (issued < ITEM_GOAL) begin
            mode     = $urandom_range(0, 2);
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = tx_quiet;
            if (phase == 2 || phase == 17) begin
                fill_list();
            end else begin
                for (int k = 0; k < PHASE_LEN && issued < ITEM_GOAL; k++) begin
                    case (mode)
                        0:       random_command(70, 8);
                        1:       random_command(15, 45);
                        default: random_command(30, 15);
                    endcase
                end
            end
            if (phase % 5 == 4)
                drain();
            phase++;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Let everything come back, then watch a little longer for strays.
        drain();
        repeat (DEPTH + 8) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/orl_pkg.sv
rtl/orl_cell.sv
rtl/ordered_record_list.sv
verif/orl_checker.sv
verif/testbench.sv
